/* hw/rtl/bsed_pkg.sv */
// Types and constants shared by the backslash escape decoder.
package bsed_pkg;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_OCTAL  = 2'd2;
    localparam logic [1:0] MODE_DONE   = 2'd3;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_C         = 8'h63;
    localparam logic [1:0] OCTAL_DIGITS_AFTER_FIRST = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eos;
        logic       rlast;
    } result_t;

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        logic [7:0] v;
        begin
            case (b)
                8'h61: v = 8'd7;
                8'h62: v = 8'd8;
                8'h65: v = 8'd27;
                8'h45: v = 8'd27;
                8'h66: v = 8'd12;
                8'h6E: v = 8'd10;
                8'h72: v = 8'd13;
                8'h74: v = 8'd9;
                8'h76: v = 8'd11;
                default: v = b;
            endcase
            return v;
        end
    endfunction

endpackage

/* hw/rtl/backslash_escape_decoder_core.sv */
// Backslash escape decoder: one input byte in, up to two decoded words out.
// Decoded words are registered into the result queue and offered on the master side from its head.
// Throughput: one byte per cycle while the result queue has room; a byte that gives two words fills two queue entries.
// The four-word result queue takes a byte while it holds two words or fewer.
// Reset (rst_n low, asynchronous) returns to normal mode and empties the queue.
module backslash_escape_decoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] run_last
    output logic       m_tlast    // end_of_string
);

    logic [1:0] mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] left_reg, left_next;

    bsed_pkg::result_t queue_reg [bsed_pkg::QUEUE_DEPTH];
    logic [bsed_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bsed_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bsed_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    bsed_pkg::result_t r0, r1;
    logic [1:0] n_res;
    logic       push, pop;
    logic       is_oct;
    logic [2:0] digit;
    logic [7:0] acc_sum;
    logic [1:0] left_dec;
    logic       stay_escape;

    assign is_oct      = (s_tdata[7:3] == 5'b00110);
    assign digit       = s_tdata[2:0];
    assign acc_sum     = {acc_reg[4:0], digit};
    assign left_dec    = left_reg - 2'd1;
    assign stay_escape = (s_tdata == bsed_pkg::CHAR_BACKSLASH) && !s_tlast;

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = 8'd0;
        left_next = 2'd0;
        n_res     = 2'd0;
        r0        = '{data: s_tdata, valid: 1'b1, eos: s_tlast, rlast: 1'b0};
        r1        = '{data: s_tdata, valid: 1'b1, eos: s_tlast, rlast: 1'b1};
        case (mode_reg)
            bsed_pkg::MODE_NORMAL:
            begin
                if (stay_escape)
                begin
                    mode_next = bsed_pkg::MODE_ESCAPE;
                end
                else
                begin
                    n_res = 2'd1;
                end
            end
            bsed_pkg::MODE_ESCAPE:
            begin
                mode_next = bsed_pkg::MODE_NORMAL;
                if (is_oct)
                begin
                    if (s_tlast)
                    begin
                        n_res   = 2'd1;
                        r0.data = {5'd0, digit};
                    end
                    else
                    begin
                        mode_next = bsed_pkg::MODE_OCTAL;
                        acc_next  = {5'd0, digit};
                        left_next = bsed_pkg::OCTAL_DIGITS_AFTER_FIRST;
                    end
                end
                else if (s_tdata == bsed_pkg::CHAR_C)
                begin
                    n_res    = 2'd1;
                    r0.data  = 8'd0;
                    r0.valid = 1'b0;
                    r0.eos   = 1'b1;
                    if (!s_tlast)
                    begin
                        mode_next = bsed_pkg::MODE_DONE;
                    end
                end
                else
                begin
                    n_res   = 2'd1;
                    r0.data = bsed_pkg::escape_map(s_tdata);
                end
            end
            bsed_pkg::MODE_OCTAL:
            begin
                if (is_oct && (left_reg != 2'd0))
                begin
                    if ((left_dec == 2'd0) || s_tlast)
                    begin
                        mode_next = bsed_pkg::MODE_NORMAL;
                        n_res     = 2'd1;
                        r0.data   = acc_sum;
                    end
                    else
                    begin
                        acc_next  = acc_sum;
                        left_next = left_dec;
                    end
                end
                else
                begin
                    r0.data = acc_reg;
                    r0.eos  = 1'b0;
                    if (stay_escape)
                    begin
                        mode_next = bsed_pkg::MODE_ESCAPE;
                        n_res     = 2'd1;
                    end
                    else
                    begin
                        mode_next = bsed_pkg::MODE_NORMAL;
                        n_res     = 2'd2;
                    end
                end
            end
            default:
            begin
                if (s_tlast)
                begin
                    mode_next = bsed_pkg::MODE_NORMAL;
                end
            end
        endcase
        r0.rlast = (n_res == 2'd1);
    end

    assign s_tready = (cnt_reg <= bsed_pkg::CNT_W'(2));
    assign push     = s_tvalid && s_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + bsed_pkg::PTR_W'(n_res);
            cnt_next    = cnt_next + bsed_pkg::CNT_W'(n_res);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + bsed_pkg::PTR_W'(1);
            cnt_next    = cnt_next - bsed_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bsed_pkg::MODE_NORMAL;
            acc_reg    <= 8'd0;
            left_reg   <= 2'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                left_reg <= left_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (n_res != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= r0;
        end
        if (push && (n_res == 2'd2))
        begin
            queue_reg[wr_ptr_reg + bsed_pkg::PTR_W'(1)] <= r1;
        end
    end

    assign m_tdata = queue_reg[rd_ptr_reg].data;
    assign m_tuser = {queue_reg[rd_ptr_reg].rlast, queue_reg[rd_ptr_reg].valid};
    assign m_tlast = queue_reg[rd_ptr_reg].eos;

endmodule

/* test/backslash_escape_decoder_core_tb.sv */
// Testbench for the backslash escape decoder core: stream stimulus, predicted words and checks.
module backslash_escape_decoder_core_tb;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CTRL_BEL   = 8'd7;
    localparam logic [7:0] CTRL_BS    = 8'd8;
    localparam logic [7:0] CTRL_TAB   = 8'd9;
    localparam logic [7:0] CTRL_LF    = 8'd10;
    localparam logic [7:0] CTRL_VT    = 8'd11;
    localparam logic [7:0] CTRL_FF    = 8'd12;
    localparam logic [7:0] CTRL_CR    = 8'd13;
    localparam logic [7:0] CTRL_ESC   = 8'd27;
    localparam int RANDOM_BYTES = 800;
    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_AT_WORD = 150;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } src_byte_t;

    class decoded_word_tracker;
        logic [1:0]          mode;
        logic [7:0]          accum;
        logic [1:0]          digits_left;
        bsed_pkg::result_t   decoded_words[$];
        bsed_pkg::result_t   fresh[$];

        function new();
            mode = bsed_pkg::MODE_NORMAL;
            accum = 8'd0;
            digits_left = 2'd0;
        endfunction

        function void emit(input logic [7:0] v, input logic valid, input logic eos);
            bsed_pkg::result_t r;
            r.data = valid ? v : 8'd0;
            r.valid = valid;
            r.eos = eos;
            r.rlast = 1'b0;
            fresh.push_back(r);
        endfunction

        function bit is_octal(input logic [7:0] b);
            return b >= CHAR_ZERO && b <= CHAR_SEVEN;
        endfunction

        function void plain_byte(input logic [7:0] b, input logic last);
            if (b == bsed_pkg::CHAR_BACKSLASH && !last)
            begin
                mode = bsed_pkg::MODE_ESCAPE;
            end
            else
            begin
                mode = bsed_pkg::MODE_NORMAL;
                emit(b, 1'b1, last);
            end
        endfunction

        function void escaped_byte(input logic [7:0] b, input logic last);
            logic [7:0] v;
            mode = bsed_pkg::MODE_NORMAL;
            if (is_octal(b))
            begin
                accum = b - CHAR_ZERO;
                digits_left = bsed_pkg::OCTAL_DIGITS_AFTER_FIRST;
                if (last)
                    emit(accum, 1'b1, 1'b1);
                else
                    mode = bsed_pkg::MODE_OCTAL;
            end
            else if (b == bsed_pkg::CHAR_C)
            begin
                if (!last)
                    mode = bsed_pkg::MODE_DONE;
                emit(8'd0, 1'b0, 1'b1);
            end
            else
            begin
                case (b)
                    "a": v = CTRL_BEL;
                    "b": v = CTRL_BS;
                    "e", "E": v = CTRL_ESC;
                    "f": v = CTRL_FF;
                    "n": v = CTRL_LF;
                    "r": v = CTRL_CR;
                    "t": v = CTRL_TAB;
                    "v": v = CTRL_VT;
                    default: v = b;
                endcase
                emit(v, 1'b1, last);
            end
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            fresh.delete();
            case (mode)
                bsed_pkg::MODE_NORMAL: plain_byte(b, last);
                bsed_pkg::MODE_ESCAPE: escaped_byte(b, last);
                bsed_pkg::MODE_OCTAL:
                begin
                    if (is_octal(b) && digits_left != 2'd0)
                    begin
                        accum = (accum << 3) + (b - CHAR_ZERO);
                        digits_left = digits_left - 2'd1;
                        if (digits_left == 2'd0 || last)
                        begin
                            mode = bsed_pkg::MODE_NORMAL;
                            emit(accum, 1'b1, last);
                        end
                    end
                    else
                    begin
                        emit(accum, 1'b1, 1'b0);
                        plain_byte(b, last);
                    end
                end
                default:
                begin
                    if (last)
                        mode = bsed_pkg::MODE_NORMAL;
                end
            endcase
            if (mode != bsed_pkg::MODE_OCTAL)
            begin
                accum = 8'd0;
                digits_left = 2'd0;
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].rlast = 1'b1;
            foreach (fresh[i])
                decoded_words.push_back(fresh[i]);
        endfunction

        function string match_word(input bsed_pkg::result_t got);
            bsed_pkg::result_t want;
            if (decoded_words.size() == 0)
                return $sformatf("unexpected word: data %02h valid %0b eos %0b rlast %0b",
                                 got.data, got.valid, got.eos, got.rlast);
            want = decoded_words.pop_front();
            if (got != want)
                return $sformatf("word mismatch: got %02h/%0b/%0b/%0b, expected %02h/%0b/%0b/%0b",
                                 got.data, got.valid, got.eos, got.rlast,
                                 want.data, want.valid, want.eos, want.rlast);
            return "";
        endfunction

        function int pending();
            return decoded_words.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    decoded_word_tracker tracker = new();
    src_byte_t source[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  send_quiet = 0;
    bit  recv_quiet = 0;

    backslash_escape_decoder_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic last);
        src_byte_t s;
        s.b = b;
        s.last = last;
        source.push_back(s);
    endfunction

    function automatic void add_text(input string txt, input logic ends);
        for (int i = 0; i < txt.len(); i++)
            add_byte(txt[i], ends && i == txt.len() - 1);
    endfunction

    function automatic void add_random_string();
        string letters;
        int tokens;
        int pick;
        int digits;
        letters = "abeEfnrtv\\'zQ0";
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 65)
            begin
                add_byte(bsed_pkg::CHAR_BACKSLASH, 1'b0);
                add_byte(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
            end
            else if (pick < 68)
            begin
                add_byte(bsed_pkg::CHAR_BACKSLASH, 1'b0);
                add_byte(bsed_pkg::CHAR_C, 1'b0);
            end
            else if (pick < 90)
            begin
                add_byte(bsed_pkg::CHAR_BACKSLASH, 1'b0);
                digits = $urandom_range(1, 4);
                for (int d = 0; d < digits; d++)
                    add_byte(8'($urandom_range(CHAR_ZERO, CHAR_SEVEN)), 1'b0);
            end
            else
            begin
                add_byte(bsed_pkg::CHAR_BACKSLASH, 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        source[source.size() - 1].last = 1'b1;
    endfunction

    task automatic offer_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_words();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        bsed_pkg::result_t got;
        string msg;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.data = m_tdata;
                got.valid = m_tuser[0];
                got.eos = m_tlast;
                got.rlast = m_tuser[1];
                msg = tracker.match_word(got);
                if (msg != "")
                    report(msg);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int words_taken;
        int gap;
        words_taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (words_taken % 40 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            if (words_taken == HOLD_AT_WORD)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = recv_quiet ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            words_taken++;
        end
    end

    initial
    begin
        int directed_count;
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_text("\\n\\E", 1'b1);
        add_text("\\101z", 1'b1);
        add_text("\\777", 1'b1);
        add_text("\\7", 1'b1);
        add_text("\\", 1'b1);
        add_text("a\\cxy", 1'b1);
        directed_count = source.size();
        while (source.size() < directed_count + RANDOM_BYTES)
            add_random_string();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < source.size(); i++)
        begin
            if (i % 64 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            if (i == source.size() / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                drain_words();
            end
            offer_byte(source[i].b, source[i].last);
        end
        s_tvalid <= 1'b0;
        drain_words();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
